FILE: hw/rtl/nrep_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nrep_pkg
// shared types and constants of the nested region event profiler
// ----------------------------------------------------------------------------
package nrep_pkg;

  localparam logic [2:0] FN_BEGIN   = 3'd0;
  localparam logic [2:0] FN_END     = 3'd1;
  localparam logic [2:0] FN_ALLOC   = 3'd2;
  localparam logic [2:0] FN_DEALLOC = 3'd3;
  localparam logic [2:0] FN_COPY    = 3'd4;
  localparam logic [2:0] FN_RDREC   = 3'd5;
  localparam logic [2:0] FN_RDCNT   = 3'd6;

  localparam logic [7:0] CAT_ALLOC    = 8'd1;
  localparam logic [7:0] CAT_DEALLOC  = 8'd2;
  localparam logic [7:0] CAT_COPY     = 8'd3;
  localparam logic [7:0] CAT_PARALLEL = 8'd4;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_NEST = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;
  localparam logic [1:0] ST_BAD  = 2'd3;

  localparam logic [3:0] C_AEV  = 4'd0;
  localparam logic [3:0] C_ABY  = 4'd1;
  localparam logic [3:0] C_DEV  = 4'd2;
  localparam logic [3:0] C_DBY  = 4'd3;
  localparam logic [3:0] C_CEV  = 4'd4;
  localparam logic [3:0] C_CBY  = 4'd5;
  localparam logic [3:0] C_PAR  = 4'd6;
  localparam logic [3:0] C_LIVE = 4'd7;
  localparam logic [3:0] C_PEAK = 4'd8;
  localparam logic [3:0] C_MIS  = 4'd9;
  localparam logic [3:0] C_TOP  = 4'd10;
  localparam logic [3:0] C_ROVF = 4'd11;
  localparam logic [3:0] C_BOVF = 4'd12;

  typedef struct packed {
    logic [2:0]  func;
    logic [63:0] event_id;
    logic [7:0]  event_category;
    logic [63:0] timestamp_ns;
    logic signed [63:0] byte_count;
    logic [11:0] read_index;
    logic [3:0]  counter_select;
  } nrep_in_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [11:0] slot;
    logic [63:0] entry_id;
    logic [7:0]  entry_category;
    logic [63:0] entry_calls;
    logic [63:0] entry_inclusive_ns;
    logic [63:0] entry_exclusive_ns;
    logic        entry_exclusive_known;
    logic [63:0] counter_value;
    logic        counter_known;
    logic [12:0] records_used;
    logic [7:0]  nesting_depth;
  } nrep_out_t;

  // one record row as stored
  typedef struct packed {
    logic [63:0] id;
    logic [7:0]  cat;
    logic [63:0] calls;
    logic [63:0] incl;
    logic [63:0] excl;
    logic        known;
  } nrep_rec_t;

  typedef struct packed {
    logic [63:0] id;
    logic [63:0] bytes;
    logic [63:0] active;
  } nrep_buf_t;

  // frame row: id, start, child, valid, record slot, category
  typedef struct packed {
    logic [63:0] id;
    logic [63:0] start;
    logic [63:0] child;
    logic        valid;
    logic [15:0] rec;
    logic [7:0]  cat;
  } nrep_frame_t;

  // search request / answer between the control and a search unit
  typedef struct packed {
    logic go;
  } nrep_srch_req_t;

  typedef struct packed {
    logic done;
    logic hit;
  } nrep_srch_rsp_t;

endpackage

FILE: hw/rtl/nrep_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nrep_ram
// generic single port ram with registered read
// ----------------------------------------------------------------------------
module nrep_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

FILE: hw/rtl/nrep_scan.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nrep_scan
// linear search address sequencer over a filled table
// ----------------------------------------------------------------------------
module nrep_scan
  import nrep_pkg::*;
#(
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     rst,
  input  nrep_srch_req_t           req,
  input  logic [$clog2(DEPTH):0]   used,
  input  logic                     match,
  output logic [$clog2(DEPTH)-1:0] addr,
  output nrep_srch_rsp_t           rsp
);
  localparam int AW = $clog2(DEPTH);

  logic [AW:0] idx;
  logic        run;
  logic        chk;

  // address idx is read now, data compared next cycle at idx-1
  always_ff @(posedge clk) begin
    if (rst) begin
      run <= 1'b0;
      chk <= 1'b0;
      rsp <= '0;
      idx <= '0;
    end else begin
      rsp <= '0;
      if (req.go) begin
        idx <= '0;
        chk <= 1'b0;
        if (used == '0) begin
          rsp.done <= 1'b1;
          run      <= 1'b0;
        end else begin
          run <= 1'b1;
        end
      end else if (run) begin
        if (chk && match) begin
          run      <= 1'b0;
          chk      <= 1'b0;
          rsp.done <= 1'b1;
          rsp.hit  <= 1'b1;
          idx      <= idx - 1'b1;
        end else if (idx == used) begin
          run      <= 1'b0;
          chk      <= 1'b0;
          rsp.done <= 1'b1;
        end else begin
          idx <= idx + 1'b1;
          chk <= 1'b1;
        end
      end
    end
  end

  assign addr = idx[AW-1:0];
endmodule

FILE: hw/rtl/nested_region_event_profiler.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nested_region_event_profiler
// profiling event engine: record table, region stack, buffer table, counters
// ----------------------------------------------------------------------------
//  channel   signals                    handshake
//  event     start, busy, in_item       taken when start && !busy
//  result    done, out_item             one cycle strobe, no backpressure
//
//  R and B the record and buffer fill counts: begin and copy scan the R filled
//  record slots, alloc and dealloc scan the B buffer slots and then the R record
//  slots; end, read record and read counter use no scan.
//  the linear scans through the single port record and buffer rams set the rate.
//  reset clears counters, flags and fill counts; ram contents need none.
//  busy is high from the accepted item and drops in the cycle of its result.
module nested_region_event_profiler
  import nrep_pkg::*;
#(
  parameter int RECORD_SLOTS = 4096,
  parameter int STACK_FRAMES = 128,
  parameter int BUFFER_SLOTS = 4096
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      start,
  input  nrep_in_t  in_item,
  output logic      busy,
  output logic      done,
  output nrep_out_t out_item
);
  localparam int RAW = $clog2(RECORD_SLOTS);
  localparam int BAW = $clog2(BUFFER_SLOTS);
  localparam int FAW = $clog2(STACK_FRAMES);
  localparam logic [63:0] ALL1 = '1;

  typedef enum logic [3:0] {
    S_IDLE, S_BSCAN, S_BRD, S_BWR, S_RSCAN, S_RRD, S_FRD, S_FRD2, S_PRD, S_PRD2,
    S_UPD, S_OUT
  } state_t;
  state_t state;

  nrep_in_t   req;
  logic [RAW:0] rec_used;
  logic [BAW:0] buf_used;
  logic [FAW:0] depth;
  logic [63:0] cnt [11];
  logic [4:0]  known;
  logic [1:0]  ovf;

  // record ram
  logic          rwe;
  logic [RAW-1:0] raddr_m;
  nrep_rec_t     rwd, rrd;
  logic [RAW-1:0] rsc_addr;
  nrep_srch_req_t rs_req;
  nrep_srch_rsp_t rs_rsp;
  logic [7:0]    key_cat;
  logic [RAW-1:0] rslot;
  logic          rvalid;
  logic          rsel;
  nrep_rec_t     rcur;

  // buffer ram
  logic          bwe;
  logic [BAW-1:0] baddr_m;
  nrep_buf_t     bwd, brd;
  logic [BAW-1:0] bsc_addr;
  nrep_srch_req_t bs_req;
  nrep_srch_rsp_t bs_rsp;
  logic          bsel;

  // frame ram
  logic          fwe;
  logic [FAW-1:0] faddr;
  nrep_frame_t   fwd, frd;
  nrep_frame_t   ftop;
  logic [63:0]   el;

  nrep_out_t     res;
  logic [1:0]    stat;

  nrep_ram #(.WIDTH($bits(nrep_rec_t)), .DEPTH(RECORD_SLOTS)) u_rec (
    .clk(clk), .we(rwe), .addr(rsel ? raddr_m : rsc_addr), .wdata(rwd), .rdata(rrd));
  nrep_ram #(.WIDTH($bits(nrep_buf_t)), .DEPTH(BUFFER_SLOTS)) u_buf (
    .clk(clk), .we(bwe), .addr(bsel ? baddr_m : bsc_addr), .wdata(bwd), .rdata(brd));
  nrep_ram #(.WIDTH($bits(nrep_frame_t)), .DEPTH(STACK_FRAMES)) u_frm (
    .clk(clk), .we(fwe), .addr(faddr), .wdata(fwd), .rdata(frd));

  nrep_scan #(.DEPTH(RECORD_SLOTS)) u_rscan (
    .clk(clk), .rst(rst), .req(rs_req), .used(rec_used),
    .match(rrd.id == req.event_id && rrd.cat == key_cat),
    .addr(rsc_addr), .rsp(rs_rsp));
  nrep_scan #(.DEPTH(BUFFER_SLOTS)) u_bscan (
    .clk(clk), .rst(rst), .req(bs_req), .used(buf_used),
    .match(brd.id == req.event_id),
    .addr(bsc_addr), .rsp(bs_rsp));

  always_comb begin
    unique case (req.func)
      FN_ALLOC:   key_cat = CAT_ALLOC;
      FN_DEALLOC: key_cat = CAT_DEALLOC;
      FN_COPY:    key_cat = CAT_COPY;
      default:    key_cat = req.event_category;
    endcase
  end

  function automatic logic [64:0] sat_add(input logic [63:0] a, input logic [63:0] b);
    logic [64:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s;
  endfunction

  assign busy = (state != S_IDLE);
  assign el = (req.timestamp_ns >= ftop.start) ? req.timestamp_ns - ftop.start : '0;

  always_ff @(posedge clk) begin
    logic [64:0] s;
    logic [63:0] ex;
    logic        neg;
    logic [63:0] live;
    nrep_rec_t   row;
    nrep_buf_t   brow;
    nrep_frame_t prow;
    if (rst) begin
      state    <= S_IDLE;
      done     <= 1'b0;
      rec_used <= '0;
      buf_used <= '0;
      depth    <= '0;
      for (int i = 0; i < 11; i++) cnt[i] <= '0;
      known    <= '1;
      ovf      <= '0;
      rs_req   <= '0;
      bs_req   <= '0;
      rwe <= 1'b0; bwe <= 1'b0; fwe <= 1'b0;
      rsel <= 1'b0; bsel <= 1'b0;
    end else begin
      done   <= 1'b0;
      rs_req <= '0;
      bs_req <= '0;
      rwe <= 1'b0; bwe <= 1'b0; fwe <= 1'b0;
      neg = req.byte_count[63];
      unique case (state)
        S_IDLE: if (start) begin
          req    <= in_item;
          stat   <= ST_OK;
          rvalid <= 1'b0;
          rsel   <= 1'b0;
          bsel   <= 1'b0;
          unique case (in_item.func)
            FN_BEGIN, FN_COPY: begin
              rs_req.go <= 1'b1;
              state     <= S_RSCAN;
            end
            FN_ALLOC, FN_DEALLOC: begin
              bs_req.go <= 1'b1;
              state     <= S_BSCAN;
            end
            FN_END: begin
              faddr <= FAW'(depth - 1'b1);
              state <= S_FRD;
            end
            FN_RDREC: begin
              rsel    <= 1'b1;
              raddr_m <= in_item.read_index[RAW-1:0];
              state   <= S_PRD;
            end
            default: state <= S_OUT;
          endcase
        end
        S_BSCAN: if (bs_rsp.done) begin
          if (bs_rsp.hit) begin
            bsel    <= 1'b1;
            baddr_m <= bsc_addr;
            state   <= S_BRD;
          end else if (buf_used == (BAW+1)'(BUFFER_SLOTS)) begin
            ovf[1] <= 1'b1;
            known[3] <= 1'b0;
            stat <= ST_FULL;
            if (req.func == FN_ALLOC) begin
              cnt[C_AEV] <= cnt[C_AEV] + 1'b1;
              if (neg) known[0] <= 1'b0;
              else begin
                s = sat_add(cnt[C_ABY], req.byte_count);
                if (s[64]) known[0] <= 1'b0; else cnt[C_ABY] <= s[63:0];
              end
            end else begin
              cnt[C_DEV] <= cnt[C_DEV] + 1'b1;
              known[1] <= 1'b0;
            end
            rs_req.go <= 1'b1;
            state <= S_RSCAN;
          end else begin
            // new buffer: initialised here, then rewritten by the update step
            bsel    <= 1'b1;
            baddr_m <= buf_used[BAW-1:0];
            buf_used <= buf_used + 1'b1;
            bwe  <= 1'b1;
            bwd  <= '{id: req.event_id, bytes: ALL1, active: '0};
            state <= S_BRD;
          end
        end
        S_BRD: begin
          // wait for registered read of the chosen buffer slot
          if (!bwe) state <= S_BWR;
        end
        S_BWR: begin
          brow = brd;
          if (req.func == FN_ALLOC) begin
            cnt[C_AEV] <= cnt[C_AEV] + 1'b1;
            live = cnt[C_LIVE];
            if (neg) begin
              known[0] <= 1'b0;
            end else begin
              s = sat_add(cnt[C_ABY], req.byte_count);
              if (s[64]) known[0] <= 1'b0; else cnt[C_ABY] <= s[63:0];
            end
            if (brd.active == '0) brow.bytes = req.byte_count;
            else if (brd.bytes != req.byte_count) brow.bytes = ALL1;
            if (brd.active == ALL1) begin
              ovf[1] <= 1'b1;
              brow.bytes = ALL1;
            end else brow.active = brd.active + 1'b1;
            // size mismatch and count overflow also clear live-known here
            s = sat_add(live, req.byte_count);
            if (!neg && known[3] && !(brd.active != '0 && brd.bytes != req.byte_count)
                && brd.active != ALL1 && !s[64]) begin
              cnt[C_LIVE] <= s[63:0];
              if (s[63:0] > cnt[C_PEAK]) cnt[C_PEAK] <= s[63:0];
            end else known[3] <= 1'b0;
          end else begin
            cnt[C_DEV] <= cnt[C_DEV] + 1'b1;
            if (brd.active != '0) begin
              if (!brd.bytes[63]) begin
                s = sat_add(cnt[C_DBY], brd.bytes);
                if (s[64]) known[1] <= 1'b0; else cnt[C_DBY] <= s[63:0];
              end else known[1] <= 1'b0;
              if (!brd.bytes[63] && known[3] && cnt[C_LIVE] >= brd.bytes)
                cnt[C_LIVE] <= cnt[C_LIVE] - brd.bytes;
              else known[3] <= 1'b0;
              brow.active = brd.active - 1'b1;
            end else begin
              known[1] <= 1'b0;
              known[3] <= 1'b0;
            end
          end
          bwd <= brow;
          bwe <= 1'b1;
          rs_req.go <= 1'b1;
          state <= S_RSCAN;
        end
        S_RSCAN: if (rs_rsp.done) begin
          rsel <= 1'b1;
          if (rs_rsp.hit) begin
            raddr_m <= rsc_addr;
            rslot   <= rsc_addr;
            rvalid  <= 1'b1;
            state   <= S_RRD;
          end else if (rec_used == (RAW+1)'(RECORD_SLOTS)) begin
            ovf[0] <= 1'b1;
            stat   <= ST_FULL;
            state  <= S_UPD;
          end else begin
            raddr_m  <= rec_used[RAW-1:0];
            rslot    <= rec_used[RAW-1:0];
            rvalid   <= 1'b1;
            rec_used <= rec_used + 1'b1;
            rwe <= 1'b1;
            rwd <= '{id: req.event_id, cat: key_cat, calls: '0, incl: '0, excl: '0,
                     known: 1'b1};
            state <= S_RRD;
          end
        end
        S_RRD: if (!rwe) state <= S_UPD;
        S_FRD: state <= S_FRD2;
        S_FRD2: begin
          ftop <= frd;
          if (depth == '0 || frd.id != req.event_id) begin
            cnt[C_MIS] <= cnt[C_MIS] + 1'b1;
            stat  <= ST_NEST;
            state <= S_OUT;
          end else begin
            depth <= depth - 1'b1;
            if (frd.valid && frd.rec < 16'(RECORD_SLOTS)) begin
              rsel    <= 1'b1;
              raddr_m <= frd.rec[RAW-1:0];
              rslot   <= frd.rec[RAW-1:0];
              rvalid  <= 1'b1;
            end else begin
              stat  <= ST_FULL;
            end
            // passing through S_RRD lets the parent frame read land
            state <= S_RRD;
            faddr <= FAW'(depth - 2'd2);
          end
        end
        S_PRD: state <= S_PRD2;
        S_PRD2: begin
          if ({4'd0, req.read_index} < 16'(rec_used)
              && {4'd0, req.read_index} < 16'(RECORD_SLOTS)) begin
            rcur   <= rrd;
            rvalid <= 1'b1;
            rslot  <= req.read_index[RAW-1:0];
          end else stat <= ST_BAD;
          state <= S_OUT;
        end
        S_UPD: begin
          row = rrd;
          if (req.func == FN_END) begin
            ex = (el >= ftop.child) ? el - ftop.child : '0;
            if (rvalid) begin
              row.incl = rrd.incl + el;
              if (ftop.cat == CAT_PARALLEL) row.known = 1'b0;
              else if (rrd.known) row.excl = rrd.excl + ex;
            end
            if (depth != '0) begin
              // parent frame is read-modified-written here in one go
              prow = frd;
              prow.child = frd.child + el;
              fwe <= 1'b1;
              fwd <= prow;
            end else if (known[4]) begin
              s = sat_add(cnt[C_TOP], el);
              if (s[64]) known[4] <= 1'b0; else cnt[C_TOP] <= s[63:0];
            end
          end else begin
            if (rvalid && !(req.func == FN_BEGIN &&
                (req.event_category == CAT_ALLOC || req.event_category == CAT_COPY)))
              row.calls = rrd.calls + 1'b1;
            if (req.func == FN_BEGIN) begin
              if (req.event_category == CAT_PARALLEL) cnt[C_PAR] <= cnt[C_PAR] + 1'b1;
              if (depth >= (FAW+1)'(STACK_FRAMES)) begin
                cnt[C_MIS] <= cnt[C_MIS] + 1'b1;
                stat <= ST_NEST;
              end else begin
                fwe   <= 1'b1;
                faddr <= depth[FAW-1:0];
                fwd   <= '{id: req.event_id, start: req.timestamp_ns, child: '0,
                           valid: rvalid, rec: rvalid ? 16'(rslot) : '0,
                           cat: req.event_category};
                depth <= depth + 1'b1;
              end
            end else if (req.func == FN_COPY) begin
              cnt[C_CEV] <= cnt[C_CEV] + 1'b1;
              if (neg) known[2] <= 1'b0;
              else begin
                s = sat_add(cnt[C_CBY], req.byte_count);
                if (s[64]) known[2] <= 1'b0; else cnt[C_CBY] <= s[63:0];
              end
            end
          end
          if (rvalid) begin
            rwe <= 1'b1;
            rwd <= row;
          end else if (req.func != FN_BEGIN || depth < (FAW+1)'(STACK_FRAMES)) begin
            stat <= ST_FULL;
          end
          rcur  <= row;
          state <= S_OUT;
        end
        S_OUT: begin
          done  <= 1'b1;
          rsel  <= 1'b0;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_comb begin
    res = '0;
    res.status = stat;
    if (req.func > FN_RDCNT) res.status = ST_BAD;
    if (rvalid) begin
      res.slot = 12'(rslot);
      res.entry_id = rcur.id;
      res.entry_category = rcur.cat;
      res.entry_calls = rcur.calls;
      res.entry_inclusive_ns = rcur.incl;
      res.entry_exclusive_ns = rcur.excl;
      res.entry_exclusive_known = rcur.known;
    end
    if (req.func == FN_RDREC) res.slot = req.read_index;
    if (req.func == FN_RDCNT) begin
      if (req.counter_select <= C_TOP) begin
        res.counter_value = cnt[req.counter_select];
        case (req.counter_select)
          C_ABY:          res.counter_known = known[0];
          C_DBY:          res.counter_known = known[1];
          C_CBY:          res.counter_known = known[2];
          C_LIVE, C_PEAK: res.counter_known = known[3];
          C_TOP:          res.counter_known = known[4];
          default:        res.counter_known = 1'b1;
        endcase
      end else if (req.counter_select == C_ROVF || req.counter_select == C_BOVF) begin
        res.counter_value = {63'd0, (req.counter_select == C_ROVF) ? ovf[0] : ovf[1]};
        res.counter_known = 1'b1;
      end else res.status = ST_BAD;
    end
    res.records_used = 13'(rec_used);
    res.nesting_depth = 8'(depth);
  end

  assign out_item = res;

`ifndef SYNTH
  a_busy_done: assert property (@(posedge clk) disable iff (rst) done |-> $past(busy))
    else $error("result without a pending item");
  a_depth: assert property (@(posedge clk) disable iff (rst)
    depth <= (FAW+1)'(STACK_FRAMES)) else $error("stack depth overrun");
  a_recused: assert property (@(posedge clk) disable iff (rst)
    rec_used <= (RAW+1)'(RECORD_SLOTS)) else $error("record fill overrun");
`endif
endmodule
